@@ hw/rtl/bba_pkg.sv @@
// Shared types and constants of the buddy block allocator.
package bba_pkg;

  localparam int Levels    = 8;
  localparam int LvW       = 3;
  localparam int IdxW      = 7;
  localparam int NodeCount = (1 << Levels) - 1;
  localparam int NodeW     = 8;
  localparam int CntW      = 8;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Datapath operation codes issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_POP_RD,
    OP_POP_WR,
    OP_PUSH,
    OP_LIST_RD,
    OP_REM_RD,
    OP_REM_WR,
    OP_REM_FIX,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic             push_odd;
    logic             res_ok;
  } dp_cmd_t;

  typedef struct packed {
    logic             lvl_bad;
    logic             idx_bad;
    logic             is_free;
    logic             cnt_zero;
    logic             scan_at_top;
    logic             scan_done;
    logic             self_listed;
    logic             buddy_listed;
    logic             cur_top;
  } dp_sts_t;

  function automatic logic [NodeW-1:0] node_id(input logic [LvW-1:0] lv,
                                               input logic [IdxW-1:0] idx);
    logic [NodeW-1:0] base;
    base = NodeW'((1 << lv) - 1);
    return base + NodeW'(idx);
  endfunction

endpackage

@@ hw/rtl/bba_ctrl.sv @@
// Controller state machine of the buddy block allocator.
module bba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             res_busy_i,
  input  bba_pkg::dp_sts_t sts_i,
  output bba_pkg::dp_cmd_t cmd_o
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN, S_SPLIT_RD, S_SPLIT_WR, S_PUSH_L, S_PUSH_R,
    S_GRANT_RD, S_GRANT_WR, S_FREE_RD, S_REM_RD, S_REM_WR, S_REM_FIX, S_DONE
  } state_e;

  state_e state_q;
  logic   ok_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o = '{op: OP_NONE, push_odd: 1'b0, res_ok: ok_q};
    unique case (state_q)
      S_IDLE:     if (in_valid_i) cmd_o.op = OP_LOAD;
      S_CHECK:    cmd_o.op = OP_NONE;
      S_SCAN:     cmd_o.op = OP_SCAN;
      S_SPLIT_RD: cmd_o.op = OP_POP_RD;
      S_SPLIT_WR: cmd_o.op = OP_POP_WR;
      S_PUSH_L:   cmd_o.op = OP_PUSH;
      S_PUSH_R: begin
        cmd_o.op = OP_PUSH;
        cmd_o.push_odd = 1'b1;
      end
      S_GRANT_RD: cmd_o.op = OP_POP_RD;
      S_GRANT_WR: cmd_o.op = OP_POP_WR;
      S_FREE_RD:  cmd_o.op = OP_LIST_RD;
      S_REM_RD:   cmd_o.op = OP_REM_RD;
      S_REM_WR:   cmd_o.op = OP_REM_WR;
      S_REM_FIX:  cmd_o.op = OP_REM_FIX;
      S_DONE:     if (!res_busy_i) cmd_o.op = OP_RESULT;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ok_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_CHECK;
        S_CHECK: begin
          ok_q <= 1'b0;
          if (sts_i.lvl_bad) state_q <= S_DONE;
          else if (!sts_i.is_free) state_q <= S_SCAN;
          else if (sts_i.idx_bad) state_q <= S_DONE;
          else state_q <= S_FREE_RD;
        end
        S_SCAN: begin
          // Walks upward one level a cycle until a stack has entries.
          if (!sts_i.cnt_zero) begin
            ok_q    <= 1'b1;
            state_q <= sts_i.scan_done ? S_GRANT_RD : S_SPLIT_RD;
          end else if (sts_i.scan_at_top) begin
            state_q <= S_DONE;
          end
        end
        S_SPLIT_RD: state_q <= S_SPLIT_WR;
        S_SPLIT_WR: state_q <= S_PUSH_L;
        // The push of a freed block is the end of that request.
        S_PUSH_L:   state_q <= sts_i.is_free ? S_DONE : S_PUSH_R;
        S_PUSH_R:   state_q <= sts_i.scan_done ? S_GRANT_RD : S_SPLIT_RD;
        S_GRANT_RD: state_q <= S_GRANT_WR;
        S_GRANT_WR: state_q <= S_DONE;
        S_FREE_RD: begin
          if (sts_i.self_listed) begin
            state_q <= S_DONE;
          end else begin
            ok_q    <= 1'b1;
            state_q <= S_REM_RD;
          end
        end
        S_REM_RD: begin
          if (sts_i.self_listed) state_q <= S_DONE;
          else if (!sts_i.cur_top && sts_i.buddy_listed) state_q <= S_REM_WR;
          else state_q <= S_PUSH_L;
        end
        S_REM_WR:  state_q <= S_REM_FIX;
        S_REM_FIX: state_q <= S_REM_RD;
        S_DONE:    if (!res_busy_i) state_q <= S_IDLE;
        default:   state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> state_q == S_CHECK)
    else $error("accepted beat did not start a request");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REM_WR) |=> state_q == S_REM_FIX)
    else $error("remove sequence broken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GRANT_RD) |=> state_q == S_GRANT_WR)
    else $error("grant sequence broken");
endmodule

@@ hw/rtl/bba_dpath.sv @@
// Datapath of the buddy block allocator: stacks, positions, listed bits, counts.
module bba_dpath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bba_pkg::dp_cmd_t         cmd_i,
  input  logic                     in_req_i,
  input  logic [bba_pkg::LvW-1:0]  in_level_i,
  input  logic [bba_pkg::IdxW-1:0] in_index_i,
  output bba_pkg::dp_sts_t         sts_o,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic                     res_ok_o,
  output logic [15:0]              res_data_o
);
  import bba_pkg::*;

  logic [IdxW-1:0] stack_mem [NodeCount];
  logic [CntW-1:0] pos_mem   [NodeCount];
  logic [NodeCount-1:0] listed_q;
  logic [CntW-1:0] cnt_q [Levels];

  logic            req_q;
  logic [LvW-1:0]  tgt_q, cur_q;
  logic [IdxW-1:0] idx_q, ci_q, pidx_q, moved_q;
  logic [CntW-1:0] pos_q;
  logic            ok_r_q;
  logic [LvW-1:0]  rl_q;
  logic [IdxW-1:0] ri_q;
  logic            res_valid_q;

  logic [LvW-1:0]  push_lv;
  logic [IdxW-1:0] push_idx;
  logic [IdxW-1:0] buddy;
  logic [LvW-1:0]  lv_m1;

  assign buddy = ci_q ^ IdxW'(1);
  assign lv_m1 = cur_q - LvW'(1);

  always_comb begin
    sts_o.lvl_bad      = 32'(tgt_q) >= Levels;
    sts_o.idx_bad      = 32'(idx_q) >= (32'd1 << tgt_q);
    sts_o.is_free      = req_q;
    sts_o.cnt_zero     = (cnt_q[cur_q] == '0);
    sts_o.scan_at_top  = (cur_q == '0);
    sts_o.scan_done    = (cur_q == tgt_q);
    sts_o.self_listed  = listed_q[node_id(cur_q, ci_q)];
    sts_o.buddy_listed = listed_q[node_id(cur_q, buddy)];
    sts_o.cur_top      = (cur_q == '0);
  end

  // Split pushes go one level down; a freed block is pushed at its own level.
  always_comb begin
    if (req_q) begin
      push_lv  = cur_q;
      push_idx = ci_q;
    end else begin
      push_lv  = cur_q;
      push_idx = {pidx_q[IdxW-2:0], cmd_i.push_odd};
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_PUSH: if (!listed_q[node_id(push_lv, push_idx)]) begin
        stack_mem[node_id(push_lv, IdxW'(cnt_q[push_lv]))] <= push_idx;
        pos_mem[node_id(push_lv, push_idx)] <= cnt_q[push_lv];
      end
      OP_REM_WR: stack_mem[node_id(cur_q, IdxW'(pos_q))] <= moved_q;
      OP_REM_FIX: pos_mem[node_id(cur_q, moved_q)] <= pos_q;
      default: ;
    endcase
    unique case (cmd_i.op)
      // Level 0 only ever holds the root, whose index is zero.
      OP_POP_RD: pidx_q <= (cur_q == '0) ? '0 :
                           stack_mem[node_id(cur_q, IdxW'(cnt_q[cur_q] - 8'd1))];
      OP_REM_RD: begin
        pos_q   <= pos_mem[node_id(cur_q, buddy)];
        moved_q <= stack_mem[node_id(cur_q, IdxW'(cnt_q[cur_q] - 8'd1))];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listed_q    <= NodeCount'(1);
      for (int i = 0; i < Levels; i++) cnt_q[i] <= (i == 0) ? CntW'(1) : '0;
      res_valid_q <= 1'b0;
      req_q <= 1'b0; tgt_q <= '0; cur_q <= '0; idx_q <= '0; ci_q <= '0;
      ok_r_q <= 1'b0; rl_q <= '0; ri_q <= '0;
    end else begin
      if (res_valid_q && res_ready_i && cmd_i.op != OP_RESULT) res_valid_q <= 1'b0;
      unique case (cmd_i.op)
        OP_LOAD: begin
          req_q <= in_req_i;
          tgt_q <= in_level_i;
          cur_q <= in_level_i;
          idx_q <= in_index_i;
          ci_q  <= in_index_i;
        end
        OP_SCAN: if (cnt_q[cur_q] == '0 && cur_q != '0) cur_q <= lv_m1;
        OP_POP_WR: begin
          listed_q[node_id(cur_q, pidx_q)] <= 1'b0;
          cnt_q[cur_q] <= cnt_q[cur_q] - CntW'(1);
          if (cur_q == tgt_q) ci_q <= pidx_q;
          else cur_q <= cur_q + LvW'(1);
        end
        OP_PUSH: begin
          if (!listed_q[node_id(push_lv, push_idx)]) begin
            listed_q[node_id(push_lv, push_idx)] <= 1'b1;
            cnt_q[push_lv] <= cnt_q[push_lv] + CntW'(1);
          end
        end
        OP_REM_WR: begin
          listed_q[node_id(cur_q, buddy)] <= 1'b0;
          cnt_q[cur_q] <= cnt_q[cur_q] - CntW'(1);
        end
        OP_REM_FIX: begin
          cur_q <= lv_m1;
          ci_q  <= ci_q >> 1;
        end
        OP_RESULT: begin
          res_valid_q <= 1'b1;
          ok_r_q <= cmd_i.res_ok;
          rl_q   <= cmd_i.res_ok ? cur_q : '0;
          ri_q   <= cmd_i.res_ok ? ci_q : '0;
        end
        default: ;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_ok_o    = ok_r_q;
  assign res_data_o  = {6'b0, ri_q, rl_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_POP_WR) |-> cnt_q[cur_q] != '0)
    else $error("pop from empty stack");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_RESULT) |-> !res_valid_q || res_ready_i)
    else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_REM_WR) |-> cnt_q[cur_q] != '0)
    else $error("remove from empty stack");
endmodule

@@ hw/rtl/buddy_block_allocator.sv @@
// Top level of the buddy block allocator.
// Usage: one request beat on the s_axis side (allocate or free) yields one
// result beat on m_axis. Request: tuser is req_type, tdata holds level [2:0]
// and block_index [9:3]. Result: tuser is ok, tdata holds result_level [2:0]
// and result_index [9:3].
// The block handles one request at a time. An allocate scans upward for a
// level with a free block and splits it one level at a time down to the
// requested level, reading and writing the stack memory at each split; a
// failed one ends when the scan finds no free block. A free merges with a
// free buddy step by step and stops early when the merge reaches an
// already free parent; a bad index or a double free ends it before any
// merge. The controller is ready for the next request as the result beat
// appears.
// After reset only the whole pool is free. The result register holds a
// finished beat while m_axis_tready is low, and the controller waits
// before writing the next one.
module buddy_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,   // req_type
  input  logic [15:0] s_axis_tdata,   // level, block_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic        m_axis_tuser,   // ok
  output logic [15:0] m_axis_tdata    // result_level, result_index
);
  import bba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .res_busy_i (m_axis_tvalid && !m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_dpath u_dpath (
    .clk_i, .rst_ni,
    .cmd_i       (cmd),
    .in_req_i    (s_axis_tuser),
    .in_level_i  (s_axis_tdata[2:0]),
    .in_index_i  (s_axis_tdata[9:3]),
    .sts_o       (sts),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_ok_o    (m_axis_tuser),
    .res_data_o  (m_axis_tdata)
  );
endmodule
